>>> rtl/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse.
// Used by m3i_det, m3i_div and matrix3x3_inverse; no dependencies.
package m3i_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_ENT       = 9;
    localparam int PROD_W        = 2 * WORD_BITS;
    localparam int COF_W         = 2 * WORD_BITS + 1;
    localparam int PART_W        = 2 * WORD_BITS + 1;
    localparam int DET_W         = 3 * WORD_BITS + 3;

    // adj[k] = m[p]*m[q] - m[s]*m[t], k in row-major order of the inverse
    localparam logic [3:0] ADJ_TERMS [0:NUM_ENT-1][0:3] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t m00;
        word_t m01;
        word_t m02;
        word_t m10;
        word_t m11;
        word_t m12;
        word_t m20;
        word_t m21;
        word_t m22;
    } m3i_in_t;

    typedef struct packed {
        word_t r00;
        word_t r01;
        word_t r02;
        word_t r10;
        word_t r11;
        word_t r12;
        word_t r20;
        word_t r21;
        word_t r22;
        logic  singular;
        logic  overflow;
    } m3i_out_t;

endpackage

>>> rtl/matrix3x3_inverse.sv
// 3x3 matrix inverse, signed fixed point: one matrix in, one inverse out per
// transfer. Top level; depends on m3i_pkg, m3i_det and m3i_div.
//
// Takes one matrix per clock, unless back-pressure from m_ready fills the
// pipeline, and returns its inverse through 5 determinant stages plus
// WORD_BITS + 4 divider stages. The divider resolves one quotient bit per
// stage for all nine entries in parallel.
// Results are rounded to nearest with ties away from zero and saturated;
// a zero determinant gives all-zero entries with singular set. Back-pressure
// from m_ready fills pipeline bubbles before s_ready drops.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  m3i_pkg::m3i_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output m3i_pkg::m3i_out_t  m_data
);
    import m3i_pkg::*;

    logic                    det_valid;
    logic                    det_ready;
    logic signed [COF_W-1:0] cof [0:NUM_ENT-1];
    logic signed [DET_W-1:0] det;

    m3i_det u_det (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (det_valid),
        .out_ready (det_ready),
        .cof       (cof),
        .det       (det)
    );

    m3i_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (det_valid),
        .in_ready  (det_ready),
        .cof       (cof),
        .det       (det),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

>>> rtl/m3i_det.sv
// Cofactor and determinant pipeline: products, cofactors, split partial
// products of row 0, terms, determinant. Depends on m3i_pkg.
module m3i_det (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  m3i_pkg::m3i_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [m3i_pkg::COF_W-1:0]     cof [0:m3i_pkg::NUM_ENT-1],
    output logic signed [m3i_pkg::DET_W-1:0]     det
);
    import m3i_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    word_t mat [0:NUM_ENT-1];

    logic signed [PROD_W-1:0] prod_reg   [0:NUM_ENT-1][0:1];
    word_t                    row1_reg   [0:2];
    logic signed [COF_W-1:0]  cof_s2_reg [0:NUM_ENT-1];
    word_t                    row2_reg   [0:2];
    logic signed [COF_W-1:0]  cof_s3_reg [0:NUM_ENT-1];
    logic signed [PART_W-1:0] plo_reg    [0:2];
    logic signed [PART_W-1:0] phi_reg    [0:2];
    logic signed [COF_W-1:0]  cof_s4_reg [0:NUM_ENT-1];
    logic signed [DET_W-1:0]  term_reg   [0:2];
    logic signed [COF_W-1:0]  cof_s5_reg [0:NUM_ENT-1];
    logic signed [DET_W-1:0]  det_reg;

    assign mat[0] = in_data.m00;
    assign mat[1] = in_data.m01;
    assign mat[2] = in_data.m02;
    assign mat[3] = in_data.m10;
    assign mat[4] = in_data.m11;
    assign mat[5] = in_data.m12;
    assign mat[6] = in_data.m20;
    assign mat[7] = in_data.m21;
    assign mat[8] = in_data.m22;

    always_comb begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (rdy[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int k = 0; k < NUM_ENT; k++) begin
                prod_reg[k][0] <= mat[ADJ_TERMS[k][0]] * mat[ADJ_TERMS[k][1]];
                prod_reg[k][1] <= mat[ADJ_TERMS[k][2]] * mat[ADJ_TERMS[k][3]];
            end
            for (int e = 0; e < 3; e++) begin
                row1_reg[e] <= mat[e];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int k = 0; k < NUM_ENT; k++) begin
                cof_s2_reg[k] <= COF_W'(prod_reg[k][0]) - COF_W'(prod_reg[k][1]);
            end
            row2_reg <= row1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int e = 0; e < 3; e++) begin
                plo_reg[e] <= PART_W'(row2_reg[e])
                    * PART_W'($signed({1'b0, cof_s2_reg[3*e][WORD_BITS-1:0]}));
                phi_reg[e] <= PART_W'(row2_reg[e])
                    * PART_W'($signed(cof_s2_reg[3*e][COF_W-1:WORD_BITS]));
            end
            cof_s3_reg <= cof_s2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            for (int e = 0; e < 3; e++) begin
                term_reg[e] <= (DET_W'(phi_reg[e]) <<< WORD_BITS) + DET_W'(plo_reg[e]);
            end
            cof_s4_reg <= cof_s3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            det_reg    <= term_reg[0] + term_reg[1] + term_reg[2];
            cof_s5_reg <= cof_s4_reg;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign cof       = cof_s5_reg;
    assign det       = det_reg;

endmodule

>>> rtl/m3i_div.sv
// Nine-lane restoring divider pipeline, one quotient bit per stage, then
// rounding, saturation and the result register. Depends on m3i_pkg.
module m3i_div #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [m3i_pkg::COF_W-1:0]     cof [0:m3i_pkg::NUM_ENT-1],
    input  logic signed [m3i_pkg::DET_W-1:0]     det,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output m3i_pkg::m3i_out_t                    out_data
);
    import m3i_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int NSTEP = W + 1;
    localparam int LAST  = NSTEP + 2;
    localparam int NUM_W = COF_W + 2 * FRAC_BITS;
    localparam int SH_W  = DET_W + W;
    localparam int RW    = (NUM_W > SH_W ? NUM_W : SH_W) + 1;
    localparam int QR_W  = W + 1;

    logic [LAST:0] vld_reg;
    logic [LAST:0] rdy;

    logic [COF_W-1:0] cmag [0:NUM_ENT-1];
    logic [DET_W-1:0] dabs;

    logic [RW-1:0]    rem_reg  [0:NSTEP][0:NUM_ENT-1];
    logic [W-1:0]     quo_reg  [0:NSTEP][0:NUM_ENT-1];
    logic [8:0]       neg_reg  [0:NSTEP];
    logic [8:0]       ovf_reg  [0:NSTEP];
    logic [DET_W-1:0] dmag_reg [0:NSTEP];
    logic [NSTEP:0]   sing_reg;

    logic [QR_W-1:0]  qr_reg [0:NUM_ENT-1];
    logic [8:0]       rneg_reg;
    logic [8:0]       rovf_reg;
    logic             rsing_reg;

    word_t            res [0:NUM_ENT-1];
    logic [8:0]       sat;
    m3i_out_t         out_next;
    m3i_out_t         out_reg;

    always_comb begin
        rdy[LAST] = !vld_reg[LAST] || out_ready;
        for (int s = LAST - 1; s >= 0; s--) begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s <= LAST; s++) begin
                if (rdy[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_ENT; l++) begin
            cmag[l] = cof[l][COF_W-1] ? -cof[l] : cof[l];
        end
        dabs = det[DET_W-1] ? -det : det;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int l = 0; l < NUM_ENT; l++) begin
                rem_reg[0][l] <= RW'(cmag[l]) << (2 * FRAC_BITS);
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= cof[l][COF_W-1] ^ det[DET_W-1];
            end
            ovf_reg[0]  <= '0;
            dmag_reg[0] <= dabs;
            sing_reg[0] <= (det == '0);
        end
    end

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int J = W - s;
        logic [RW-1:0] dsh;
        logic [8:0]    ge;

        assign dsh = RW'(dmag_reg[s]) << J;

        always_comb begin
            for (int l = 0; l < NUM_ENT; l++) begin
                ge[l] = rem_reg[s][l] >= dsh;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[s+1]) begin
                for (int l = 0; l < NUM_ENT; l++) begin
                    if (ge[l] && J != W) begin
                        rem_reg[s+1][l] <= rem_reg[s][l] - dsh;
                        quo_reg[s+1][l] <= quo_reg[s][l] | (W'(1) << J);
                    end else begin
                        rem_reg[s+1][l] <= rem_reg[s][l];
                        quo_reg[s+1][l] <= quo_reg[s][l];
                    end
                    ovf_reg[s+1][l] <= ovf_reg[s][l] | (ge[l] && J == W);
                end
                neg_reg[s+1]  <= neg_reg[s];
                dmag_reg[s+1] <= dmag_reg[s];
                sing_reg[s+1] <= sing_reg[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NSTEP+1]) begin
            for (int l = 0; l < NUM_ENT; l++) begin
                qr_reg[l] <= QR_W'(quo_reg[NSTEP][l])
                    + QR_W'({rem_reg[NSTEP][l], 1'b0} >= (RW + 1)'(dmag_reg[NSTEP]));
            end
            rneg_reg  <= neg_reg[NSTEP];
            rovf_reg  <= ovf_reg[NSTEP];
            rsing_reg <= sing_reg[NSTEP];
        end
    end

    always_comb begin
        logic [QR_W-1:0] lim;
        logic [QR_W-1:0] mag;
        logic [QR_W-1:0] sval;
        for (int l = 0; l < NUM_ENT; l++) begin
            lim = rneg_reg[l] ? (QR_W'(1) << (W - 1)) : (QR_W'(1) << (W - 1)) - QR_W'(1);
            sat[l] = rovf_reg[l] || (qr_reg[l] > lim);
            mag = sat[l] ? lim : qr_reg[l];
            sval = rneg_reg[l] ? -mag : mag;
            res[l] = rsing_reg ? '0 : sval[W-1:0];
        end
        out_next.r00      = res[0];
        out_next.r01      = res[1];
        out_next.r02      = res[2];
        out_next.r10      = res[3];
        out_next.r11      = res[4];
        out_next.r12      = res[5];
        out_next.r20      = res[6];
        out_next.r21      = res[7];
        out_next.r22      = res[8];
        out_next.singular = rsing_reg;
        out_next.overflow = !rsing_reg && (sat != '0);
    end

    always_ff @(posedge aclk) begin
        if (rdy[LAST]) begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[LAST];
    assign out_data  = out_reg;

    localparam word_t SAT_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam word_t SAT_MIN = {1'b1, {(W - 1){1'b0}}};

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_reg.singular |->
            !out_reg.overflow && out_reg.r00 == '0 && out_reg.r01 == '0
            && out_reg.r02 == '0 && out_reg.r10 == '0 && out_reg.r11 == '0
            && out_reg.r12 == '0 && out_reg.r20 == '0 && out_reg.r21 == '0
            && out_reg.r22 == '0)
        else $error("singular result with nonzero entries");

    a_overflow_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_reg.overflow |->
            out_reg.r00 == SAT_MAX || out_reg.r00 == SAT_MIN
            || out_reg.r01 == SAT_MAX || out_reg.r01 == SAT_MIN
            || out_reg.r02 == SAT_MAX || out_reg.r02 == SAT_MIN
            || out_reg.r10 == SAT_MAX || out_reg.r10 == SAT_MIN
            || out_reg.r11 == SAT_MAX || out_reg.r11 == SAT_MIN
            || out_reg.r12 == SAT_MAX || out_reg.r12 == SAT_MIN
            || out_reg.r20 == SAT_MAX || out_reg.r20 == SAT_MIN
            || out_reg.r21 == SAT_MAX || out_reg.r21 == SAT_MIN
            || out_reg.r22 == SAT_MAX || out_reg.r22 == SAT_MIN)
        else $error("overflow flagged with no saturated entry");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !rdy[0] |-> vld_reg[LAST] && !out_ready)
        else $error("input stalled while the pipeline has room");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix3x3_inverse: drives matrices, predicts
// each inverse with exact wide integer arithmetic, checks every transfer.
// Depends on m3i_pkg and the matrix3x3_inverse RTL.
module testbench;
    import m3i_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int LIMIT    = 2000000;
    localparam int BIG_W    = 192;
    localparam int ONE_Q    = 1 << FRAC;

    typedef logic signed [BIG_W-1:0] big_t;
    typedef logic [BIG_W-1:0] mag_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    m3i_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    m3i_out_t m_data;

    m3i_out_t inverse_q[$];
    int       idle_pct  = 0;
    int       stall_pct = 0;
    int       mismatches = 0;
    int       cycles = 0;

    matrix3x3_inverse #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic m3i_out_t predict_inverse(input m3i_in_t mat);
        logic [9*WORD_BITS-1:0] flat;
        big_t     ent[9];
        big_t     cof[9];
        big_t     det, num;
        mag_t     dmag, nmag, quo, rem, lim;
        logic     neg, ovf;
        m3i_out_t res;
        flat = mat;
        for (int k = 0; k < 9; k++)
            ent[k] = big_t'($signed(flat[WORD_BITS*(8-k) +: WORD_BITS]));
        for (int k = 0; k < 9; k++)
            cof[k] = ent[ADJ_TERMS[k][0]] * ent[ADJ_TERMS[k][1]]
                   - ent[ADJ_TERMS[k][2]] * ent[ADJ_TERMS[k][3]];
        det = ent[0] * cof[0] + ent[1] * cof[3] + ent[2] * cof[6];
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        dmag = (det < 0) ? mag_t'(-det) : mag_t'(det);
        ovf = 1'b0;
        flat = '0;
        for (int k = 0; k < 9; k++) begin
            num  = cof[k] <<< (2 * FRAC);
            neg  = (num < 0) != (det < 0);
            nmag = (num < 0) ? mag_t'(-num) : mag_t'(num);
            quo  = nmag / dmag;
            rem  = nmag % dmag;
            if ((rem << 1) >= dmag) quo = quo + 1;
            lim = mag_t'(1) << (WORD_BITS - 1);
            if (!neg) lim = lim - 1;
            if (quo > lim) begin
                quo = lim;
                ovf = 1'b1;
            end
            if (neg) quo = -quo;
            flat[WORD_BITS*(8-k) +: WORD_BITS] = quo[WORD_BITS-1:0];
        end
        res = {flat, 1'b0, ovf};
        return res;
    endfunction

    task automatic send_matrix(input m3i_in_t mat);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= mat;
        do @(posedge aclk); while (!s_ready);
        inverse_q.push_back(predict_inverse(mat));
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic m3i_in_t diag_matrix(input word_t a, input word_t b, input word_t c);
        m3i_in_t mat;
        mat = '0;
        mat.m00 = a;
        mat.m11 = b;
        mat.m22 = c;
        return mat;
    endfunction

    function automatic word_t rand_word(input int span);
        return word_t'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic m3i_in_t rand_matrix();
        m3i_in_t mat;
        int      kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1: begin
                mat = {$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
            end
            2: begin
                mat = {$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
                mat.m20 = mat.m00;
                mat.m21 = mat.m01;
                mat.m22 = mat.m02;
            end
            3: begin
                mat = '0;
                mat.m00 = rand_word(1 << $urandom_range(4, 30));
                mat.m01 = rand_word(1 << $urandom_range(4, 30));
                mat.m10 = mat.m00;
                mat.m11 = mat.m01;
                mat.m22 = rand_word(1 << 20);
            end
            4: begin
                mat = diag_matrix(rand_word(1 << 8), rand_word(1 << 8), rand_word(1 << 8));
            end
            default: begin
                mat = {rand_word(1 << 20), rand_word(1 << 18), rand_word(1 << 18),
                       rand_word(1 << 18), rand_word(1 << 20), rand_word(1 << 18),
                       rand_word(1 << 18), rand_word(1 << 18), rand_word(1 << 20)};
                mat.m00 = mat.m00 + 4 * ONE_Q;
                mat.m11 = mat.m11 - 4 * ONE_Q;
                mat.m22 = mat.m22 + 4 * ONE_Q;
            end
        endcase
        return mat;
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        logic [9*WORD_BITS+1:0] got, want;
        m3i_out_t exp_out;
        if (aresetn && m_valid && m_ready) begin
            if (inverse_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h", m_data);
            end else begin
                exp_out = inverse_q.pop_front();
                got  = m_data;
                want = exp_out;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        for (int k = 0; k < 9; k++)
                            if (got[2+WORD_BITS*(8-k) +: WORD_BITS]
                                    != want[2+WORD_BITS*(8-k) +: WORD_BITS])
                                $display("r%0d%0d: expected %h, got %h", k / 3, k % 3,
                                         want[2+WORD_BITS*(8-k) +: WORD_BITS],
                                         got[2+WORD_BITS*(8-k) +: WORD_BITS]);
                        if (got[1] != want[1])
                            $display("singular: expected %b, got %b", want[1], got[1]);
                        if (got[0] != want[0])
                            $display("overflow: expected %b, got %b", want[0], got[0]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        m3i_in_t mat;
        send_matrix(diag_matrix(ONE_Q, ONE_Q, ONE_Q));
        send_matrix('0);
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'h7fff_ffff}});
        send_matrix(diag_matrix(1, 1, 1));
        send_matrix(diag_matrix(-1, 1, -1));
        send_matrix(diag_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag_matrix(2 * ONE_Q, -4 * ONE_Q, ONE_Q / 2));
        send_matrix(diag_matrix(3, 3, 3));
        send_matrix(diag_matrix(ONE_Q, ONE_Q, 2));
        send_matrix(diag_matrix(3 * ONE_Q, ONE_Q, ONE_Q));
        send_matrix(diag_matrix(-3 * ONE_Q, 7 * ONE_Q, -ONE_Q));
        send_matrix(diag_matrix(ONE_Q, ONE_Q, 0));
        mat = {32'(ONE_Q), 32'(2 * ONE_Q), 32'(3 * ONE_Q), 32'(4 * ONE_Q), 32'(5 * ONE_Q),
               32'(6 * ONE_Q), 32'(7 * ONE_Q), 32'(8 * ONE_Q), 32'(10 * ONE_Q)};
        send_matrix(mat);
        mat.m22 = 9 * ONE_Q;
        send_matrix(mat);
        mat = {32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
               32'h1, 32'h0, 32'hffff_ffff, 32'h8000_0000};
        send_matrix(mat);
        mat = {32'hffff_ffff, 32'h1, 32'h0, 32'h0, 32'hffff_ffff, 32'h1,
               32'h1, 32'h0, 32'hffff_ffff};
        send_matrix(mat);
        mat = {32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f,
               32'hf0f0_f0f0, 32'h3333_3333, 32'hcccc_cccc, 32'h7f00_00ff};
        send_matrix(mat);
        go_idle();
    endtask

    task automatic test_random(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) send_matrix(rand_matrix());
        go_idle();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(0, 0, 450);
        test_random(56, 0, 450);
        test_random(0, 56, 450);
        test_random(37, 37, 450);
        while (inverse_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
